>>> src/mips_alu_pkg.sv
package mips_alu_pkg;

    localparam int unsigned DataW = 32;

    // primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'd0;
    localparam logic [5:0] OP_JAL     = 6'd3;
    localparam logic [5:0] OP_ADDI    = 6'd8;
    localparam logic [5:0] OP_ADDIU   = 6'd9;
    localparam logic [5:0] OP_SLTI    = 6'd10;
    localparam logic [5:0] OP_ANDI    = 6'd12;
    localparam logic [5:0] OP_ORI     = 6'd13;
    localparam logic [5:0] OP_NORI    = 6'd14;
    localparam logic [5:0] OP_LUI     = 6'd15;
    localparam logic [5:0] OP_LB      = 6'd32;
    localparam logic [5:0] OP_LH      = 6'd33;
    localparam logic [5:0] OP_LW      = 6'd35;
    localparam logic [5:0] OP_LBU     = 6'd36;
    localparam logic [5:0] OP_LHU     = 6'd37;
    localparam logic [5:0] OP_SB      = 6'd40;
    localparam logic [5:0] OP_SH      = 6'd41;
    localparam logic [5:0] OP_SW      = 6'd43;
    localparam logic [5:0] OP_HALT    = 6'd63;

    // r-type function codes
    localparam logic [5:0] FN_SLL   = 6'd0;
    localparam logic [5:0] FN_SRL   = 6'd2;
    localparam logic [5:0] FN_SRA   = 6'd3;
    localparam logic [5:0] FN_MFHI  = 6'd16;
    localparam logic [5:0] FN_MFLO  = 6'd18;
    localparam logic [5:0] FN_MULT  = 6'd24;
    localparam logic [5:0] FN_MULTU = 6'd25;
    localparam logic [5:0] FN_ADD   = 6'd32;
    localparam logic [5:0] FN_ADDU  = 6'd33;
    localparam logic [5:0] FN_SUB   = 6'd34;
    localparam logic [5:0] FN_AND   = 6'd36;
    localparam logic [5:0] FN_OR    = 6'd37;
    localparam logic [5:0] FN_XOR   = 6'd38;
    localparam logic [5:0] FN_NOR   = 6'd39;
    localparam logic [5:0] FN_NAND  = 6'd40;
    localparam logic [5:0] FN_SLT   = 6'd42;

    typedef struct packed {
        logic [5:0]              opcode;
        logic [5:0]              funct;
        logic [4:0]              shift_amount;
        logic [15:0]             immediate;
        logic signed [DataW-1:0] rs_value;
        logic signed [DataW-1:0] rt_value;
        logic [DataW-1:0]        link_value;
    } item_t;

    typedef struct packed {
        logic [DataW-1:0] result_word;
        logic             number_overflow;
        logic             hilo_overwrite;
        logic             halt;
    } result_t;

    typedef struct packed {
        logic [DataW-1:0] hi_word;
        logic [DataW-1:0] lo_word;
        logic             mult_seen;
        logic             hilo_read;
    } hilo_state_t;

    typedef struct packed {
        logic             hilo_we;
        logic [DataW-1:0] hi_word;
        logic [DataW-1:0] lo_word;
        logic             flags_we;
        logic             mult_seen;
        logic             hilo_read;
    } hilo_upd_t;

endpackage

>>> src/mips_alu_exec.sv
module mips_alu_exec (
    input  mips_alu_pkg::item_t       item,
    input  mips_alu_pkg::hilo_state_t hilo,
    output mips_alu_pkg::result_t     res,
    output mips_alu_pkg::hilo_upd_t   upd
);
    import mips_alu_pkg::*;

    logic [DataW-1:0]        a;
    logic [DataW-1:0]        b;
    logic [DataW-1:0]        se;
    logic [DataW-1:0]        ze;
    logic [DataW-1:0]        sum_rr;
    logic [DataW-1:0]        diff_rr;
    logic [DataW-1:0]        sum_ri;
    logic signed [DataW:0]   a_ext;
    logic signed [DataW:0]   b_ext;
    logic signed [2*DataW+1:0] prod;
    logic                    is_signed_mul;

    assign a       = item.rs_value;
    assign b       = item.rt_value;
    assign se      = {{(DataW-16){item.immediate[15]}}, item.immediate};
    assign ze      = {{(DataW-16){1'b0}}, item.immediate};
    assign sum_rr  = a + b;
    assign diff_rr = a - b;
    assign sum_ri  = a + se;

    // one extra bit lets a single signed multiplier serve mult and multu
    assign is_signed_mul = (item.funct == FN_MULT);
    assign a_ext = $signed({is_signed_mul & a[DataW-1], a});
    assign b_ext = $signed({is_signed_mul & b[DataW-1], b});
    assign prod  = a_ext * b_ext;

    always_comb
    begin
        res             = '0;
        upd.hilo_we     = 1'b0;
        upd.hi_word     = prod[2*DataW-1:DataW];
        upd.lo_word     = prod[DataW-1:0];
        upd.flags_we    = 1'b0;
        upd.mult_seen   = hilo.mult_seen;
        upd.hilo_read   = hilo.hilo_read;

        if (item.opcode == OP_SPECIAL)
        begin
            unique case (item.funct) inside
                FN_ADD:
                begin
                    res.result_word     = sum_rr;
                    res.number_overflow = ~(a[DataW-1] ^ b[DataW-1])
                                          & (a[DataW-1] ^ sum_rr[DataW-1]);
                end
                FN_ADDU: res.result_word = sum_rr;
                FN_SUB:
                begin
                    res.result_word     = diff_rr;
                    res.number_overflow = (a[DataW-1] ^ b[DataW-1])
                                          & (a[DataW-1] ^ diff_rr[DataW-1]);
                end
                FN_AND:  res.result_word = a & b;
                FN_OR:   res.result_word = a | b;
                FN_XOR:  res.result_word = a ^ b;
                FN_NOR:  res.result_word = ~(a | b);
                FN_NAND: res.result_word = ~(a & b);
                FN_SLT:  res.result_word = {{(DataW-1){1'b0}},
                                            ($signed(a) < $signed(b))};
                FN_SLL:  res.result_word = b << item.shift_amount;
                FN_SRL:  res.result_word = b >> item.shift_amount;
                FN_SRA:  res.result_word = $unsigned($signed(b) >>> item.shift_amount);
                FN_MULT, FN_MULTU:
                begin
                    res.result_word = item.link_value;
                    upd.hilo_we     = 1'b1;
                    if (hilo.mult_seen && hilo.hilo_read)
                    begin
                        upd.flags_we  = 1'b1;
                        upd.hilo_read = 1'b0;
                    end
                    else if (hilo.mult_seen)
                    begin
                        // previous product never read back
                        res.hilo_overwrite = 1'b1;
                    end
                    else
                    begin
                        upd.flags_we  = 1'b1;
                        upd.mult_seen = 1'b1;
                        upd.hilo_read = 1'b0;
                    end
                end
                FN_MFHI:
                begin
                    res.result_word = hilo.hi_word;
                    upd.flags_we    = 1'b1;
                    upd.hilo_read   = 1'b1;
                end
                FN_MFLO:
                begin
                    res.result_word = hilo.lo_word;
                    upd.flags_we    = 1'b1;
                    upd.hilo_read   = 1'b1;
                end
                default: ;
            endcase
        end
        else
        begin
            unique case (item.opcode) inside
                OP_ADDI, OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW:
                begin
                    res.result_word     = sum_ri;
                    res.number_overflow = ~(a[DataW-1] ^ se[DataW-1])
                                          & (a[DataW-1] ^ sum_ri[DataW-1]);
                end
                OP_ADDIU: res.result_word = sum_ri;
                OP_LUI:   res.result_word = {item.immediate, {(DataW-16){1'b0}}};
                OP_ANDI:  res.result_word = a & ze;
                OP_ORI:   res.result_word = a | ze;
                OP_NORI:  res.result_word = ~(a | ze);
                OP_SLTI:  res.result_word = {{(DataW-1){1'b0}},
                                             ($signed(a) < $signed(se))};
                OP_JAL:   res.result_word = item.link_value;
                OP_HALT:  res.halt        = 1'b1;
                default: ;
            endcase
        end
    end

endmodule

>>> src/mips_alu_hilo.sv
module mips_alu_hilo (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  mips_alu_pkg::hilo_upd_t   upd,
    output mips_alu_pkg::hilo_state_t hilo
);
    import mips_alu_pkg::*;

    logic [DataW-1:0] hi_reg, hi_next;
    logic [DataW-1:0] lo_reg, lo_next;
    logic             seen_reg, seen_next;
    logic             read_reg, read_next;

    always_comb
    begin
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        seen_next = seen_reg;
        read_next = read_reg;
        if (en && upd.hilo_we)
        begin
            hi_next = upd.hi_word;
            lo_next = upd.lo_word;
        end
        if (en && upd.flags_we)
        begin
            seen_next = upd.mult_seen;
            read_next = upd.hilo_read;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_reg   <= '0;
            lo_reg   <= '0;
            seen_reg <= 1'b0;
            read_reg <= 1'b0;
        end
        else
        begin
            hi_reg   <= hi_next;
            lo_reg   <= lo_next;
            seen_reg <= seen_next;
            read_reg <= read_next;
        end
    end

    assign hilo.hi_word   = hi_reg;
    assign hilo.lo_word   = lo_reg;
    assign hilo.mult_seen = seen_reg;
    assign hilo.hilo_read = read_reg;

endmodule

>>> src/mips_alu_hilo_with_error_flags_unit.sv
// execute stage of a mips-style core with hi/lo multiplier and error flags
//
// input channel (s_axis_*): one decoded instruction per transfer; the operation
// selector (opcode, funct) travels in tuser, the operands in tdata
// output channel (m_axis_*): one result per instruction, in order: alu value
// or effective address plus overflow, hi/lo overwrite and halt flags
//
// path: an accepted transfer waits in the input register until the result
// register is free, then its result moves there and shows on m_axis_*
// throughput: one instruction per cycle while m_axis_tready stays high;
// the 33x33 multiplier and the alu sit in the single stage between the two
// registers, and hi/lo and the overwrite tracking bits update at the edge
// the result is registered, so mfhi/mflo right behind mult see the new
// product
//
// when m_axis_tready is low the result register holds; the input register
// still takes a transfer while it is empty, so s_axis_tready drops only when
// both registers are full
// reset clears both valid flags, hi, lo and the tracking bits
module mips_alu_hilo_with_error_flags_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // shift_amount[4:0], immediate[20:5], rs_value[52:21], rt_value[84:53],
    // link_value[116:85], zero pad[119:117]
    input  logic [119:0] s_axis_tdata,
    // opcode[5:0], funct[11:6]
    input  logic [11:0]  s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_word[31:0], number_overflow[32], hilo_overwrite[33], halt[34],
    // zero pad[39:35]
    output logic [39:0]  m_axis_tdata
);
    import mips_alu_pkg::*;

    // input stage
    logic        in_valid_reg, in_valid_next;
    item_t       item_reg;
    item_t       item_in;

    // result stage
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg;

    result_t     res;
    hilo_upd_t   upd;
    hilo_state_t hilo;
    logic        advance;
    logic        in_xfer;

    assign item_in.opcode       = s_axis_tuser[5:0];
    assign item_in.funct        = s_axis_tuser[11:6];
    assign item_in.shift_amount = s_axis_tdata[4:0];
    assign item_in.immediate    = s_axis_tdata[20:5];
    assign item_in.rs_value     = $signed(s_axis_tdata[52:21]);
    assign item_in.rt_value     = $signed(s_axis_tdata[84:53]);
    assign item_in.link_value   = s_axis_tdata[116:85];

    // the instruction moves into the result register when that slot is free
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_xfer)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            item_reg <= item_in;
        if (advance)
            out_reg <= res;
    end

    mips_alu_exec u_exec (
        .item (item_reg),
        .hilo (hilo),
        .res  (res),
        .upd  (upd)
    );

    // state commits only when the instruction actually leaves the stage
    mips_alu_hilo u_hilo (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .upd   (upd),
        .hilo  (hilo)
    );

    assign m_axis_tvalid       = out_valid_reg;
    assign m_axis_tdata[31:0]  = out_reg.result_word;
    assign m_axis_tdata[32]    = out_reg.number_overflow;
    assign m_axis_tdata[33]    = out_reg.hilo_overwrite;
    assign m_axis_tdata[34]    = out_reg.halt;
    assign m_axis_tdata[39:35] = 5'b0;

endmodule

>>> tb/mips_alu_hilo_with_error_flags_unit_tb.sv
module mips_alu_hilo_with_error_flags_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mips_alu_pkg::*;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // instruction stream into the block
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // shift_amount[4:0], immediate[20:5], rs_value[52:21], rt_value[84:53],
    // link_value[116:85], zero pad[119:117]
    logic [119:0] s_axis_tdata  = '0;
    // opcode[5:0], funct[11:6]
    logic [11:0]  s_axis_tuser  = '0;

    // result stream out of the block
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // result_word[31:0], number_overflow[32], hilo_overwrite[33], halt[34],
    // zero pad[39:35]
    logic [39:0]  m_axis_tdata;

    // instructions waiting to be driven, and results owed by the block
    item_t   instr_q[$];
    result_t owed_q[$];

    // mirror of the hi/lo register pair and its overwrite tracking bits
    logic [DataW-1:0] hi_mirror     = '0;
    logic [DataW-1:0] lo_mirror     = '0;
    logic             mult_pending  = 1'b0;
    logic             hilo_consumed = 1'b0;

    // when set, neither side inserts bubbles or stalls
    logic steady  = 1'b0;
    int   err_cnt = 0;

    mips_alu_hilo_with_error_flags_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 clk = ~clk;

    // executes one instruction against the mirrored hi/lo state
    function automatic result_t alu_execute(item_t ins);
        logic [DataW-1:0] a;
        logic [DataW-1:0] b;
        logic [DataW-1:0] sext_imm;
        logic [DataW-1:0] zext_imm;
        logic [DataW-1:0] r;
        logic [63:0]      prod;
        result_t          res;
        a        = ins.rs_value;
        b        = ins.rt_value;
        sext_imm = {{16{ins.immediate[15]}}, ins.immediate};
        zext_imm = {16'b0, ins.immediate};
        r        = '0;
        res      = '0;
        if (ins.opcode == OP_SPECIAL)
        begin
            case (ins.funct) inside
                FN_ADD:
                begin
                    r = a + b;
                    res.number_overflow = ~(a[31] ^ b[31]) & (a[31] ^ r[31]);
                end
                FN_ADDU: r = a + b;
                FN_SUB:
                begin
                    r = a - b;
                    // operand signs differ and the difference flips away from rs
                    res.number_overflow = (a[31] ^ b[31]) & (a[31] ^ r[31]);
                end
                FN_AND:  r = a & b;
                FN_OR:   r = a | b;
                FN_XOR:  r = a ^ b;
                FN_NOR:  r = ~(a | b);
                FN_NAND: r = ~(a & b);
                FN_SLT:  r = {31'b0, $signed(a) < $signed(b)};
                FN_SLL:  r = b << ins.shift_amount;
                FN_SRL:  r = b >> ins.shift_amount;
                FN_SRA:  r = $signed(b) >>> ins.shift_amount;
                FN_MULT, FN_MULTU:
                begin
                    // result field just carries the link value
                    r = ins.link_value;
                    if (mult_pending && hilo_consumed)
                        hilo_consumed = 1'b0;
                    else if (mult_pending)
                        res.hilo_overwrite = 1'b1;
                    else
                    begin
                        mult_pending  = 1'b1;
                        hilo_consumed = 1'b0;
                    end
                    if (ins.funct == FN_MULT)
                        prod = {{32{a[31]}}, a} * {{32{b[31]}}, b};
                    else
                        prod = {32'b0, a} * {32'b0, b};
                    hi_mirror = prod[63:32];
                    lo_mirror = prod[31:0];
                end
                FN_MFHI:
                begin
                    r = hi_mirror;
                    hilo_consumed = 1'b1;
                end
                FN_MFLO:
                begin
                    r = lo_mirror;
                    hilo_consumed = 1'b1;
                end
                default: r = '0;
            endcase
        end
        else
        begin
            case (ins.opcode) inside
                // addi and the load/store address add share the overflow check
                OP_ADDI, OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW:
                begin
                    r = a + sext_imm;
                    res.number_overflow = ~(a[31] ^ sext_imm[31]) & (a[31] ^ r[31]);
                end
                OP_ADDIU: r = a + sext_imm;
                OP_LUI:   r = {ins.immediate, 16'b0};
                OP_ANDI:  r = a & zext_imm;
                OP_ORI:   r = a | zext_imm;
                OP_NORI:  r = ~(a | zext_imm);
                OP_SLTI:  r = {31'b0, $signed(a) < $signed(sext_imm)};
                OP_JAL:   r = ins.link_value;
                OP_HALT:  res.halt = 1'b1;
                default:  r = '0;
            endcase
        end
        res.result_word = r;
        return res;
    endfunction

    // operand with a bias toward the sign and carry corners
    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'hffff_ffff;
            3:       return 32'h7fff_ffff;
            4:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_imm();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'h7fff;
            2:       return 16'h8000;
            3:       return 16'hffff;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    // r-type function, now and then a code the block does not know
    function automatic logic [5:0] pick_funct();
        case ($urandom_range(16))
            0:       return FN_SLL;
            1:       return FN_SRL;
            2:       return FN_SRA;
            3:       return FN_MFHI;
            4:       return FN_MFLO;
            5:       return FN_MULT;
            6:       return FN_MULTU;
            7:       return FN_ADD;
            8:       return FN_ADDU;
            9:       return FN_SUB;
            10:      return FN_AND;
            11:      return FN_OR;
            12:      return FN_XOR;
            13:      return FN_NOR;
            14:      return FN_NAND;
            15:      return FN_SLT;
            default: return 6'($urandom_range(63));
        endcase
    endfunction

    // non-special opcode, now and then any 6-bit value
    function automatic logic [5:0] pick_opcode();
        case ($urandom_range(17))
            0:       return OP_JAL;
            1:       return OP_ADDI;
            2:       return OP_ADDIU;
            3:       return OP_SLTI;
            4:       return OP_ANDI;
            5:       return OP_ORI;
            6:       return OP_NORI;
            7:       return OP_LUI;
            8:       return OP_LB;
            9:       return OP_LH;
            10:      return OP_LW;
            11:      return OP_LBU;
            12:      return OP_LHU;
            13:      return OP_SB;
            14:      return OP_SH;
            15:      return OP_SW;
            16:      return OP_HALT;
            default: return 6'($urandom_range(63));
        endcase
    endfunction

    function automatic item_t random_instr();
        item_t ins;
        ins.shift_amount = 5'($urandom_range(31));
        ins.immediate    = pick_imm();
        ins.rs_value     = pick_word();
        ins.rt_value     = pick_word();
        ins.link_value   = $urandom;
        // r-type ops get a big share so mult/mfhi/mflo sequences are frequent
        if ($urandom_range(99) < 45)
        begin
            ins.opcode = OP_SPECIAL;
            ins.funct  = pick_funct();
        end
        else
        begin
            ins.opcode = pick_opcode();
            ins.funct  = 6'($urandom_range(63));
        end
        return ins;
    endfunction

    task automatic queue_instr(input logic [5:0] op, input logic [5:0] fn,
                               input logic [4:0] sh, input logic [15:0] imm,
                               input logic [31:0] rs, input logic [31:0] rt,
                               input logic [31:0] link);
        item_t ins;
        ins.opcode       = op;
        ins.funct        = fn;
        ins.shift_amount = sh;
        ins.immediate    = imm;
        ins.rs_value     = rs;
        ins.rt_value     = rt;
        ins.link_value   = link;
        instr_q.push_back(ins);
    endtask

    task automatic queue_random(input int count);
        repeat (count) instr_q.push_back(random_instr());
    endtask

    // blocks until every queued instruction has been sent and answered
    task automatic wait_drained();
        while (instr_q.size() != 0 || s_axis_tvalid || owed_q.size() != 0)
            @(posedge clk);
    endtask

    // driver: updates the mirror on each accepted transfer, then offers the
    // next instruction unless a bubble is drawn
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        item_t   taken;
        item_t   nxt;
        result_t res;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                // decode what actually went across the bus
                taken.opcode       = s_axis_tuser[5:0];
                taken.funct        = s_axis_tuser[11:6];
                taken.shift_amount = s_axis_tdata[4:0];
                taken.immediate    = s_axis_tdata[20:5];
                taken.rs_value     = s_axis_tdata[52:21];
                taken.rt_value     = s_axis_tdata[84:53];
                taken.link_value   = s_axis_tdata[116:85];
                res = alu_execute(taken);
                owed_q.push_back(res);
            end
            // a held transfer may only change once it has been taken
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (instr_q.size() != 0 && (steady || $urandom_range(99) >= 15))
                begin
                    nxt = instr_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {3'b0, nxt.link_value, nxt.rt_value, nxt.rs_value,
                                      nxt.immediate, nxt.shift_amount};
                    s_axis_tuser  <= {nxt.funct, nxt.opcode};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: random back-pressure, each result checked against the oldest
    // outstanding one
    always @(posedge clk or negedge rst_n)
    begin : check_proc
        result_t want;
        result_t got;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.result_word     = m_axis_tdata[31:0];
                got.number_overflow = m_axis_tdata[32];
                got.hilo_overwrite  = m_axis_tdata[33];
                got.halt            = m_axis_tdata[34];
                if (owed_q.size() == 0)
                begin
                    err_cnt = err_cnt + 1;
                    if (err_cnt <= 10)
                        $display("%0t: unexpected res=%h ovf=%b hov=%b halt=%b",
                                 $realtime, got.result_word, got.number_overflow,
                                 got.hilo_overwrite, got.halt);
                end
                else
                begin
                    want = owed_q.pop_front();
                    if (got.result_word !== want.result_word
                        || got.number_overflow !== want.number_overflow
                        || got.hilo_overwrite !== want.hilo_overwrite
                        || got.halt !== want.halt)
                    begin
                        err_cnt = err_cnt + 1;
                        if (err_cnt <= 10)
                            $display({"%0t: mismatch exp res=%h ovf=%b hov=%b halt=%b,",
                                      " got res=%h ovf=%b hov=%b halt=%b"},
                                     $realtime, want.result_word, want.number_overflow,
                                     want.hilo_overwrite, want.halt, got.result_word,
                                     got.number_overflow, got.hilo_overwrite, got.halt);
                    end
                end
            end
            m_axis_tready <= steady || $urandom_range(99) >= 15;
        end
    end

    // stimulus sequence
    initial
    begin
        // directed corners: overflow edges, every r-type op and some i-type ops, hi/lo tracking, halt, unknowns
        queue_instr(OP_SPECIAL, FN_MFHI, 5'd0, 16'h0, 32'h1, 32'h2, 32'h0);
        queue_instr(OP_SPECIAL, FN_ADD, 5'd0, 16'h0, 32'h7fff_ffff, 32'h1, 32'h0);
        queue_instr(OP_SPECIAL, FN_ADD, 5'd0, 16'h0, 32'h8000_0000, 32'hffff_ffff, 32'h0);
        queue_instr(OP_SPECIAL, FN_ADDU, 5'd0, 16'h0, 32'h7fff_ffff, 32'h1, 32'h0);
        queue_instr(OP_SPECIAL, FN_SUB, 5'd0, 16'h0, 32'h8000_0000, 32'h1, 32'h0);
        queue_instr(OP_SPECIAL, FN_SUB, 5'd0, 16'h0, 32'h7fff_ffff, 32'hffff_ffff, 32'h0);
        queue_instr(OP_SPECIAL, FN_AND, 5'd0, 16'h0, 32'hf0f0_f0f0, 32'hff00_ff00, 32'h0);
        queue_instr(OP_SPECIAL, FN_OR, 5'd0, 16'h0, 32'hf0f0_f0f0, 32'h0f0f_0000, 32'h0);
        queue_instr(OP_SPECIAL, FN_XOR, 5'd0, 16'h0, 32'hffff_ffff, 32'h1234_5678, 32'h0);
        queue_instr(OP_SPECIAL, FN_NOR, 5'd0, 16'h0, 32'h0, 32'h0, 32'h0);
        queue_instr(OP_SPECIAL, FN_NAND, 5'd0, 16'h0, 32'hffff_ffff, 32'hffff_ffff, 32'h0);
        queue_instr(OP_SPECIAL, FN_SLT, 5'd0, 16'h0, 32'h8000_0000, 32'h7fff_ffff, 32'h0);
        queue_instr(OP_SPECIAL, FN_SLL, 5'd31, 16'h0, 32'h0, 32'hffff_ffff, 32'h0);
        queue_instr(OP_SPECIAL, FN_SRL, 5'd31, 16'h0, 32'h0, 32'h8000_0000, 32'h0);
        queue_instr(OP_SPECIAL, FN_SRA, 5'd31, 16'h0, 32'h0, 32'h8000_0000, 32'h0);
        // first mult, second mult without a read flags overwrite, read, then
        // a mult after the read clears the read bit quietly
        queue_instr(OP_SPECIAL, FN_MULT, 5'd0, 16'h0, 32'hffff_ffff, 32'h8000_0000,
                    32'hdead_beef);
        queue_instr(OP_SPECIAL, FN_MULT, 5'd0, 16'h0, 32'h8000_0000, 32'h8000_0000,
                    32'h0000_0040);
        queue_instr(OP_SPECIAL, FN_MFLO, 5'd0, 16'h0, 32'h0, 32'h0, 32'h0);
        queue_instr(OP_SPECIAL, FN_MULTU, 5'd0, 16'h0, 32'hffff_ffff, 32'hffff_ffff,
                    32'hffff_ffff);
        queue_instr(OP_SPECIAL, FN_MFHI, 5'd0, 16'h0, 32'h0, 32'h0, 32'h0);
        queue_instr(OP_ADDI, 6'd0, 5'd0, 16'h0001, 32'h7fff_ffff, 32'h0, 32'h0);
        queue_instr(OP_LW, 6'd0, 5'd0, 16'h8000, 32'h8000_0000, 32'h0, 32'h0);
        queue_instr(OP_SB, 6'd0, 5'd0, 16'hfffc, 32'h0000_1000, 32'h0, 32'h0);
        queue_instr(OP_LUI, 6'd0, 5'd0, 16'hffff, 32'h0, 32'h0, 32'h0);
        queue_instr(OP_NORI, 6'd0, 5'd0, 16'hffff, 32'h8000_0000, 32'h0, 32'h0);
        queue_instr(OP_SLTI, 6'd0, 5'd0, 16'hffff, 32'h8000_0000, 32'h0, 32'h0);
        queue_instr(OP_JAL, 6'd0, 5'd0, 16'h0, 32'h0, 32'h0, 32'hcafe_f00d);
        queue_instr(OP_HALT, 6'd0, 5'd0, 16'h0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        queue_instr(6'd5, 6'd0, 5'd0, 16'hffff, 32'hffff_ffff, 32'h1, 32'h0);
        queue_instr(OP_SPECIAL, 6'd8, 5'd0, 16'h0, 32'hffff_ffff, 32'h1, 32'h0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // sender holds off until every directed result is back
        wait_drained();

        // random traffic with bubbles and stalls
        queue_random(680);
        while (instr_q.size() != 0)
            @(posedge clk);

        // long run at full rate on both sides
        steady = 1'b1;
        queue_random(560);
        while (instr_q.size() != 0)
            @(posedge clk);
        steady = 1'b0;

        queue_random(680);
        wait_drained();

        // catch any stray result beyond the two-stage latency
        repeat (20) @(posedge clk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("timeout waiting for results");
        $display("DONE: errors detected");
        $finish;
    end

endmodule
